@@ sv/dmsrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsrt_pkg
// Shared types, codes and score helpers for the search result table.
// ----------------------------------------------------------------------------
`default_nettype none

package dmsrt_pkg;

  localparam int KEY_W          = 64;
  localparam int PLY_W          = 6;
  localparam int SCORE_W        = 16;
  localparam int DEPTH_W        = 6;
  localparam int MOVE_W         = 25;
  localparam int CNT_W          = 32;
  localparam int THR_W          = 15;
  localparam int TABLE_ENTRIES  = 1024;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [THR_W-1:0] MATE_THR_RESET = 15'd29000;

  // item kind
  typedef enum logic [0:0] {
    ACT_PROBE = 1'b0,
    ACT_SAVE  = 1'b1
  } action_t;

  // stored bound kind
  typedef enum logic [1:0] {
    BOUND_NONE  = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_EXACT = 2'd3
  } bound_t;

  // input word
  typedef struct packed {
    action_t                    action;
    logic [KEY_W-1:0]           pos_key;
    logic [PLY_W-1:0]           ply;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    logic [DEPTH_W-1:0]         depth;
    logic [MOVE_W-1:0]          entry_move;
    logic signed [SCORE_W-1:0]  entry_score;
    bound_t                     bound_kind;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                       hit;
    logic [MOVE_W-1:0]          found_move;
    logic                       cutoff;
    logic signed [SCORE_W-1:0]  result_score;
    logic [CNT_W-1:0]           new_write_count;
    logic [CNT_W-1:0]           overwrite_count;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    action_t                    action;
    logic [KEY_W-1:0]           pos_key;
    logic [PLY_W-1:0]           ply;
    logic signed [SCORE_W-1:0]  alpha;
    logic signed [SCORE_W-1:0]  beta;
    logic [DEPTH_W-1:0]         depth;
    logic [MOVE_W-1:0]          entry_move;
    logic signed [SCORE_W-1:0]  save_score;
    bound_t                     bound_kind;
  } cmd_t;

  // one table slot
  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic [MOVE_W-1:0]          move;
    logic signed [SCORE_W-1:0]  score;
    logic [DEPTH_W-1:0]         depth;
    bound_t                     bound;
  } slot_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back status seen by the top level
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // clamp a 17-bit sum to the 16-bit signed range
  function automatic logic signed [SCORE_W-1:0] sat16(input logic signed [SCORE_W:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[SCORE_W-1:0];
    end
  endfunction

  // move a mate score by the ply, outward on save, inward on probe
  function automatic logic signed [SCORE_W-1:0] mate_adjust(
    input logic signed [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]          ply,
    input logic [THR_W-1:0]          thr,
    input logic                      outward
  );
    logic signed [SCORE_W:0] s_x;
    logic signed [SCORE_W:0] thr_x;
    logic signed [SCORE_W:0] ply_x;
    logic signed [SCORE_W:0] sum;
    s_x   = {s[SCORE_W-1], s};
    thr_x = {2'b00, thr};
    ply_x = {{(SCORE_W+1-PLY_W){1'b0}}, ply};
    sum   = s_x;
    if (s_x > thr_x) begin
      sum = outward ? s_x + ply_x : s_x - ply_x;
    end else if (s_x < -thr_x) begin
      sum = outward ? s_x - ply_x : s_x + ply_x;
    end
    return sat16(sum);
  endfunction

endpackage

`default_nettype wire

@@ sv/dmsrt_front.sv @@
// ----------------------------------------------------------------------------
// dmsrt_front
// Takes an item, works out its slot and the pushed-out save score, hands
// the command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsrt_front #(
  parameter int TABLE_ENTRIES = dmsrt_pkg::TABLE_ENTRIES,
  parameter int IDX_W         = 10
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          take,
  input  dmsrt_pkg::in_word_t          in_word,
  input  wire [dmsrt_pkg::THR_W-1:0]   mate_thr,
  input  dmsrt_pkg::q_stat_t           q_stat,
  output logic                         front_busy,
  output logic                         push,
  output dmsrt_pkg::cmd_t              push_cmd,
  output logic [IDX_W-1:0]             push_idx
);

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  logic              f_valid_r;
  dmsrt_pkg::cmd_t   f_cmd_r;
  logic              f_done;
  logic [IDX_W-1:0]  f_idx;

  // held command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (take) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd_r.action     <= in_word.action;
      f_cmd_r.pos_key    <= in_word.pos_key;
      f_cmd_r.ply        <= in_word.ply;
      f_cmd_r.alpha      <= in_word.alpha;
      f_cmd_r.beta       <= in_word.beta;
      f_cmd_r.depth      <= in_word.depth;
      f_cmd_r.entry_move <= in_word.entry_move;
      f_cmd_r.save_score <= dmsrt_pkg::mate_adjust(in_word.entry_score, in_word.ply,
                                                   mate_thr, 1'b1);
      f_cmd_r.bound_kind <= in_word.bound_kind;
    end
  end

  // slot index: a mask for power-of-two sizes, else a serial remainder
  if (IS_POW2) begin : g_mask
    assign f_idx  = IDX_W'(TABLE_ENTRIES - 1) & f_cmd_r.pos_key[IDX_W-1:0];
    assign f_done = 1'b1;
  end else begin : g_serial
    localparam int DIGIT_W = 4;
    localparam int STEPS   = dmsrt_pkg::KEY_W / DIGIT_W;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam logic [IDX_W:0] NMOD = (IDX_W + 1)'(TABLE_ENTRIES);

    logic [dmsrt_pkg::KEY_W-1:0] sh_r;
    logic [IDX_W:0]              rem_r;
    logic [IDX_W:0]              rem_nxt;
    logic [CNT_W-1:0]            cnt_r;

    // one hex digit of the key per cycle, most significant first
    always_comb begin
      rem_nxt = rem_r;
      for (int i = 0; i < DIGIT_W; i++) begin
        rem_nxt = {rem_nxt[IDX_W-1:0], sh_r[dmsrt_pkg::KEY_W-1-i]};
        if (rem_nxt >= NMOD) begin
          rem_nxt = rem_nxt - NMOD;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (take) begin
        cnt_r <= '0;
      end else if (f_valid_r && (cnt_r != CNT_W'(STEPS))) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (take) begin
        sh_r  <= in_word.pos_key;
        rem_r <= '0;
      end else if (f_valid_r && (cnt_r != CNT_W'(STEPS))) begin
        sh_r  <= sh_r << DIGIT_W;
        rem_r <= rem_nxt;
      end
    end

    assign f_idx  = rem_r[IDX_W-1:0];
    assign f_done = (cnt_r == CNT_W'(STEPS));
  end

  // hand-off to the queue
  assign push       = f_valid_r && f_done && !q_stat.full;
  assign push_cmd   = f_cmd_r;
  assign push_idx   = f_idx;
  assign front_busy = f_valid_r && !push;

endmodule

`default_nettype wire

@@ sv/dmsrt_queue.sv @@
// ----------------------------------------------------------------------------
// dmsrt_queue
// Short command queue between the front and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsrt_queue #(
  parameter int IDX_W = 10
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  dmsrt_pkg::cmd_t       push_cmd,
  input  wire [IDX_W-1:0]       push_idx,
  input  wire                   pop,
  output dmsrt_pkg::q_stat_t    q_stat,
  output dmsrt_pkg::cmd_t       head_cmd,
  output logic [IDX_W-1:0]      head_idx
);

  localparam int DEPTH = dmsrt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    dmsrt_pkg::cmd_t   cmd;
    logic [IDX_W-1:0]  idx;
  } q_ent_t;

  q_ent_t            ent_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= '{cmd: push_cmd, idx: push_idx};
    end
  end

  assign head_cmd     = ent_r[rd_ptr_r].cmd;
  assign head_idx     = ent_r[rd_ptr_r].idx;
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

@@ sv/dmsrt_back.sv @@
// ----------------------------------------------------------------------------
// dmsrt_back
// Owns the slot memory: clearing pass, slot read, probe evaluation, save
// write with forwarding, counters and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsrt_back #(
  parameter int TABLE_ENTRIES = dmsrt_pkg::TABLE_ENTRIES,
  parameter int IDX_W         = 10
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [dmsrt_pkg::THR_W-1:0]   mate_thr,
  input  dmsrt_pkg::q_stat_t           q_stat,
  input  dmsrt_pkg::cmd_t              head_cmd,
  input  wire [IDX_W-1:0]              head_idx,
  output logic                         pop,
  output dmsrt_pkg::back_stat_t        back_stat,
  output logic                         out_valid,
  output dmsrt_pkg::out_word_t         out_word
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  dmsrt_pkg::slot_t  mem [TABLE_ENTRIES];
  dmsrt_pkg::slot_t  rdata_r;

  logic              clr_r;
  logic [IDX_W-1:0]  clr_idx_r;

  logic              s1_valid_r;
  dmsrt_pkg::cmd_t   s1_cmd_r;
  logic [IDX_W-1:0]  s1_idx_r;

  logic              fwd_valid_r;
  logic [IDX_W-1:0]  fwd_idx_r;
  dmsrt_pkg::slot_t  fwd_data_r;

  logic [dmsrt_pkg::CNT_W-1:0] new_cnt_r, new_cnt_nxt;
  logic [dmsrt_pkg::CNT_W-1:0] ovw_cnt_r, ovw_cnt_nxt;

  logic                  out_valid_r;
  dmsrt_pkg::out_word_t  out_word_r, out_word_nxt;

  dmsrt_pkg::slot_t      slot;
  dmsrt_pkg::slot_t      wr_slot;
  logic                  is_save;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic signed [dmsrt_pkg::SCORE_W-1:0] adj_score;

  // clearing pass after reset, one slot a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_IDX) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign back_stat.clearing = clr_r;
  assign pop = !q_stat.empty && !clr_r;

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cmd_r <= head_cmd;
      s1_idx_r <= head_idx;
    end
  end

  // slot memory, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_slot;
    end
    rdata_r <= mem[head_idx];
  end

  // take the previous save when it hit the same slot
  assign slot    = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : rdata_r;
  assign is_save = s1_valid_r && (s1_cmd_r.action == dmsrt_pkg::ACT_SAVE);

  // write port
  always_comb begin
    wr_slot.key   = s1_cmd_r.pos_key;
    wr_slot.move  = s1_cmd_r.entry_move;
    wr_slot.score = s1_cmd_r.save_score;
    wr_slot.depth = s1_cmd_r.depth;
    wr_slot.bound = s1_cmd_r.bound_kind;
    wr_addr       = s1_idx_r;
    if (clr_r) begin
      wr_slot = '0;
      wr_addr = clr_idx_r;
    end
  end
  assign wr_en = clr_r || is_save;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= is_save;
    end
  end

  always_ff @(posedge clk) begin
    if (is_save) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= wr_slot;
    end
  end

  // save counters
  always_comb begin
    new_cnt_nxt = new_cnt_r;
    ovw_cnt_nxt = ovw_cnt_r;
    if (is_save) begin
      if (slot.key == '0) begin
        new_cnt_nxt = new_cnt_r + 1'b1;
      end else begin
        ovw_cnt_nxt = ovw_cnt_r + 1'b1;
      end
    end
  end

  assign adj_score = dmsrt_pkg::mate_adjust(slot.score, s1_cmd_r.ply, mate_thr, 1'b0);

  // probe evaluation
  always_comb begin
    logic                                 hit;
    logic                                 deep;
    logic                                 cut;
    logic signed [dmsrt_pkg::SCORE_W-1:0] s;
    hit  = (s1_cmd_r.action == dmsrt_pkg::ACT_PROBE) && (slot.key == s1_cmd_r.pos_key);
    deep = (slot.depth >= s1_cmd_r.depth);
    s    = adj_score;
    cut  = 1'b0;
    unique case (slot.bound)
      dmsrt_pkg::BOUND_UPPER: begin
        if (s <= s1_cmd_r.alpha) begin
          s   = s1_cmd_r.alpha;
          cut = 1'b1;
        end
      end
      dmsrt_pkg::BOUND_LOWER: begin
        if (s >= s1_cmd_r.beta) begin
          s   = s1_cmd_r.beta;
          cut = 1'b1;
        end
      end
      dmsrt_pkg::BOUND_EXACT: begin
        cut = 1'b1;
      end
      default: begin
        cut = 1'b0;
      end
    endcase
    out_word_nxt.hit             = hit;
    out_word_nxt.found_move      = hit ? slot.move : '0;
    out_word_nxt.cutoff          = hit && deep && cut;
    out_word_nxt.result_score    = (hit && deep) ? s : '0;
    out_word_nxt.new_write_count = new_cnt_nxt;
    out_word_nxt.overwrite_count = ovw_cnt_nxt;
  end

  // counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_cnt_r   <= '0;
      ovw_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      new_cnt_r   <= new_cnt_nxt;
      ovw_cnt_r   <= ovw_cnt_nxt;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

@@ sv/direct_mapped_search_result_table.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_search_result_table
// Path: a taken word is held in the front, queued, read against its slot, then
//   registered as the result word and strobe; other table sizes first work out the slot by a serial remainder.
// Throughput: one word per cycle for power-of-two sizes when not clearing, set
//   by the single slot memory read/write pair; other sizes wait on each remainder.
// Reset: clears the counters, then sweeps every slot to zero, one slot a
//   cycle with busy high; results are never stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_search_result_table #(
  parameter int TABLE_ENTRIES = dmsrt_pkg::TABLE_ENTRIES
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  dmsrt_pkg::in_word_t          in_word,
  output logic                         out_valid,
  output dmsrt_pkg::out_word_t         out_word,
  input  wire                          cfg_we,
  input  wire [dmsrt_pkg::THR_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [dmsrt_pkg::THR_W-1:0] mate_thr_r;
  logic                        take;
  logic                        front_busy;
  logic                        push;
  logic                        pop;
  dmsrt_pkg::cmd_t             push_cmd;
  dmsrt_pkg::cmd_t             head_cmd;
  logic [IDX_W-1:0]            push_idx;
  logic [IDX_W-1:0]            head_idx;
  dmsrt_pkg::q_stat_t          q_stat;
  dmsrt_pkg::back_stat_t       back_stat;

  // mate threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_thr_r <= dmsrt_pkg::MATE_THR_RESET;
    end else if (cfg_we) begin
      mate_thr_r <= cfg_wdata;
    end
  end

  // command handshake
  assign busy = back_stat.clearing || front_busy;
  assign take = start && !busy;

  dmsrt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_word    (in_word),
    .mate_thr   (mate_thr_r),
    .q_stat     (q_stat),
    .front_busy (front_busy),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_idx   (push_idx)
  );

  dmsrt_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .push_idx (push_idx),
    .pop      (pop),
    .q_stat   (q_stat),
    .head_cmd (head_cmd),
    .head_idx (head_idx)
  );

  dmsrt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mate_thr  (mate_thr_r),
    .q_stat    (q_stat),
    .head_cmd  (head_cmd),
    .head_idx  (head_idx),
    .pop       (pop),
    .back_stat (back_stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

@@ sv/dmsrt_checker.sv @@
// ----------------------------------------------------------------------------
// dmsrt_checker
// Port-level checks on the search result table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmsrt_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   busy,
  input wire                   out_valid,
  input dmsrt_pkg::out_word_t  out_word
);

  // reset starts the clearing sweep
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // reset drops the result strobe
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // a miss or a save carries no move, score or cutoff
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.hit) |->
      (out_word.found_move == '0 && out_word.result_score == '0 && !out_word.cutoff))
    else $error("payload on a word without a hit");

  // counters move by at most one per word
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n)) |->
      ((out_word.new_write_count - $past(out_word.new_write_count)) +
       (out_word.overwrite_count - $past(out_word.overwrite_count)) <= 32'd1))
    else $error("save counters jumped");

endmodule

bind direct_mapped_search_result_table dmsrt_checker u_dmsrt_checker (.*);

`default_nettype wire
